// ----- hw/rtl/rwqm_pkg.sv -----
// Package: shared types, constants and codes for the resource wait queue manager.
package rwqm_pkg;

   localparam int NUM_RESOURCES_DEFAULT = 32;
   localparam int NUM_PROCESSES_DEFAULT = 32;

   typedef enum logic [1:0] {
      OP_REQUEST = 2'd0,
      OP_RELEASE = 2'd1,
      OP_KILL    = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_NOT_OWNER = 3'd2,
      ST_FREE      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] resource_id;
      logic [4:0] process_id;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       owner_valid;
      logic [4:0] owner_id;
      logic [5:0] queue_length;
      logic [5:0] removed_count;
   } rsp_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_CNT,     // count read issued, wait for data
      FSM_DECIDE,  // count known, choose action
      FSM_SCAN,    // issue read of queue entry
      FSM_CMP,     // compare entry data
      FSM_SHIFT,   // copy entry k+1 to k
      FSM_FINISH,  // commit count, read head
      FSM_HEAD,    // head data returns
      FSM_NEXTRES, // kill: advance resource
      FSM_CLEAR,   // sweep counts to zero
      FSM_DONE
   } fsm_type;

endpackage

// ----- hw/rtl/resource_wait_queue_manager.sv -----
// Top level: lock manager with one FIFO wait queue per resource in RAM.
//
//  channel | ports                        | handshake
//  --------+------------------------------+------------------------------
//  request | start, busy, req_data        | taken when start && !busy
//  result  | rsp_valid, rsp_data          | one-cycle strobe, no stall
//
// A request walks its queue through one RAM read port, reading and then
// comparing each entry while busy is high.
// A release shifts the queue one entry per cycle.
// A kill visits every resource in turn, scanning each filled queue, and
// a clear sweeps the count memory to zero. Reset clears control state
// and starts the same sweep with busy high.
// The result strobes in the same cycle that busy drops; the receiver cannot stall.
module resource_wait_queue_manager
   import rwqm_pkg::*;
#(
   parameter int NUM_RESOURCES = NUM_RESOURCES_DEFAULT,
   parameter int NUM_PROCESSES = NUM_PROCESSES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int PW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
   localparam int CW = $clog2(NUM_PROCESSES + 1);
   localparam int SW = RW + PW;
   localparam int SD = 2 ** SW;

   fsm_type state_ff, state_in;
   op_type            op_ff, op_in;
   logic [RW-1:0]     cur_ff, cur_in;      // resource being worked on
   logic [4:0]        pid_ff, pid_in;
   logic [CW-1:0]     n_ff, n_in;          // count of current queue
   logic [CW-1:0]     k_ff, k_in;          // scan / shift position
   logic [2:0]        status_ff, status_in;
   logic [5:0]        removed_ff, removed_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // count memory
   logic          c_we;
   logic [RW-1:0] c_waddr, c_raddr;
   logic [CW-1:0] c_wdata, c_rdata;
   // queue store
   logic          q_we;
   logic [SW-1:0] q_waddr, q_raddr;
   logic [4:0]    q_wdata, q_rdata;

   rwqm_ram #(.WIDTH(CW), .DEPTH(NUM_RESOURCES)) u_count (
      .clock, .wr_en(c_we), .wr_addr(c_waddr), .wr_data(c_wdata),
      .rd_addr(c_raddr), .rd_data(c_rdata));

   rwqm_ram #(.WIDTH(5), .DEPTH(SD)) u_store (
      .clock, .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata));

   function automatic logic [SW-1:0] qaddr(logic [RW-1:0] r, logic [CW-1:0] k);
      return {r, k[PW-1:0]};
   endfunction

   // fold the resource id into range through a small constant table
   logic [RW-1:0] res_mod;
   always_comb begin
      res_mod = '0;
      for (int i = 0; i < 32; i++) begin
         if (req_data.resource_id == 5'(i)) res_mod = RW'(i % NUM_RESOURCES);
      end
   end

   assign busy      = (state_ff != FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (start) state_in = (req_data.op == OP_CLEAR) ? FSM_CLEAR : FSM_CNT;
         end
         FSM_CNT: state_in = FSM_DECIDE;
         FSM_DECIDE: begin
            if (op_ff == OP_KILL) state_in = (c_rdata == '0) ? FSM_NEXTRES : FSM_SCAN;
            else if (op_ff == OP_RELEASE)
               state_in = (c_rdata == '0) ? FSM_FINISH : FSM_CMP;
            else if (c_rdata == '0 || 32'(c_rdata) >= NUM_PROCESSES)
               state_in = FSM_FINISH;
            else state_in = FSM_SCAN;
         end
         FSM_SCAN: state_in = FSM_CMP;
         FSM_CMP: begin
            if (q_rdata == pid_ff) begin
               if (op_ff == OP_REQUEST) state_in = FSM_FINISH;
               else state_in = (k_ff + 1'b1 < n_ff) ? FSM_SHIFT : FSM_FINISH;
            end else if (op_ff == OP_RELEASE) state_in = FSM_FINISH;
            else if (k_ff + 1'b1 < n_ff) state_in = FSM_SCAN;
            else state_in = FSM_FINISH;
         end
         FSM_SHIFT: state_in = (k_ff + 2'd2 < n_ff) ? FSM_SHIFT : FSM_FINISH;
         FSM_FINISH: state_in = (op_ff == OP_KILL) ? FSM_NEXTRES : FSM_HEAD;
         FSM_HEAD: state_in = FSM_DONE;
         FSM_NEXTRES: begin
            if (32'(cur_ff) == NUM_RESOURCES - 1) state_in = FSM_DONE;
            else state_in = FSM_CNT;
         end
         FSM_CLEAR: begin
            if (32'(cur_ff) == NUM_RESOURCES - 1) state_in = FSM_DONE;
         end
         FSM_DONE: state_in = FSM_IDLE;
         default: state_in = FSM_IDLE;
      endcase
   end

   // datapath, memory controls and result
   always_comb begin
      op_in = op_ff; cur_in = cur_ff; pid_in = pid_ff;
      n_in = n_ff; k_in = k_ff; status_in = status_ff; removed_in = removed_ff;
      found_in = found_ff; rsp_valid_in = 1'b0; rsp_in = rsp_ff;
      c_we = 1'b0; c_waddr = cur_ff; c_wdata = n_ff; c_raddr = cur_ff;
      q_we = 1'b0; q_waddr = qaddr(cur_ff, k_ff); q_wdata = pid_ff;
      q_raddr = qaddr(cur_ff, k_ff);
      unique case (state_ff)
         FSM_IDLE: begin
            // latch the request and fetch the count
            op_in = op_type'(req_data.op); pid_in = req_data.process_id;
            status_in = ST_OK; removed_in = '0;
            k_in = '0; found_in = 1'b0;
            cur_in = (req_data.op == OP_KILL || req_data.op == OP_CLEAR) ? '0 : res_mod;
            c_raddr = cur_in;
         end
         FSM_DECIDE: begin
            n_in = c_rdata; k_in = '0; found_in = 1'b0;
            q_raddr = qaddr(cur_ff, '0);
            if (op_ff == OP_REQUEST) begin
               if (c_rdata == '0) begin
                  // empty: take it at once
                  q_we = 1'b1; q_waddr = qaddr(cur_ff, '0); n_in = CW'(1);
               end else if (32'(c_rdata) >= NUM_PROCESSES) status_in = ST_QUEUED;
            end else if (op_ff == OP_RELEASE && c_rdata == '0) status_in = ST_FREE;
         end
         FSM_CMP: begin
            if (q_rdata == pid_ff) begin
               if (op_ff == OP_REQUEST) status_in = ST_QUEUED;
               else begin
                  found_in = 1'b1;
                  q_raddr = qaddr(cur_ff, k_ff + 1'b1);
               end
            end else if (op_ff == OP_RELEASE) status_in = ST_NOT_OWNER;
            else if (k_ff + 1'b1 < n_ff) k_in = k_ff + 1'b1;
            else if (op_ff == OP_REQUEST) begin
               // absent: append at tail
               q_we = 1'b1; q_waddr = qaddr(cur_ff, n_ff);
               n_in = n_ff + 1'b1;
            end
         end
         FSM_SHIFT: begin
            // move entry k+1 down; read k+2 for the next step
            q_we = 1'b1; q_waddr = qaddr(cur_ff, k_ff); q_wdata = q_rdata;
            q_raddr = qaddr(cur_ff, k_ff + 2'd2);
            k_in = k_ff + 1'b1;
         end
         FSM_FINISH: begin
            if (found_ff) begin
               n_in = n_ff - 1'b1;
               if (op_ff == OP_KILL) removed_in = removed_ff + 1'b1;
            end
            c_we = 1'b1; c_wdata = n_in;
            q_raddr = qaddr(cur_ff, '0);
         end
         FSM_HEAD: begin
            rsp_in.status = status_ff; rsp_in.removed_count = '0;
            rsp_in.owner_valid = (n_ff != '0);
            rsp_in.owner_id = (n_ff != '0) ? q_rdata : 5'd0;
            rsp_in.queue_length = 6'(n_ff);
         end
         FSM_NEXTRES: begin
            found_in = 1'b0; k_in = '0;
            cur_in = cur_ff + 1'b1; c_raddr = cur_in;
            if (32'(cur_ff) == NUM_RESOURCES - 1) begin
               rsp_in.status = (removed_ff == '0) ? ST_NOT_FOUND : ST_OK;
               rsp_in.owner_valid = 1'b0; rsp_in.owner_id = '0;
               rsp_in.queue_length = '0; rsp_in.removed_count = removed_ff;
            end
         end
         FSM_CLEAR: begin
            c_we = 1'b1; c_wdata = '0; cur_in = cur_ff + 1'b1;
            if (32'(cur_ff) == NUM_RESOURCES - 1) begin
               rsp_in.status = ST_OK; rsp_in.owner_valid = 1'b0;
               rsp_in.owner_id = '0; rsp_in.queue_length = '0;
               rsp_in.removed_count = '0;
            end
         end
         FSM_DONE: rsp_valid_in = (op_ff != OP_CLEAR) || !found_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // sweep counts after reset; found marks it as silent
         state_ff <= FSM_CLEAR; cur_ff <= '0; op_ff <= OP_CLEAR;
         found_ff <= 1'b1; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cur_ff <= cur_in; op_ff <= op_in;
         found_ff <= found_in; rsp_valid_ff <= rsp_valid_in;
      end
      pid_ff <= pid_in; n_ff <= n_in; k_ff <= k_in;
      status_ff <= status_in; removed_ff <= removed_in; rsp_ff <= rsp_in;
   end
endmodule

// ----- hw/rtl/rwqm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module rwqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/rwqm_checker.sv -----
// Checker: port-level properties of the resource wait queue manager.
module rwqm_checker
   import rwqm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted request did not raise busy");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_owner_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.owner_valid == (rsp_data.queue_length != 6'd0)))
      else $error("owner flag disagrees with queue length");
   a_no_owner_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.owner_valid |-> rsp_data.owner_id == 5'd0)
      else $error("owner id without owner");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_NOT_FOUND) else $error("bad status");
endmodule

bind resource_wait_queue_manager rwqm_checker u_rwqm_checker (.*);

// ----- dv/tb_top.sv -----
// Testbench for the resource wait queue manager: directed table plus random requests.
module tb_top;
   import rwqm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NRES = 32;
   localparam int NPROC = 32;
   localparam int RANDOM_REQUESTS = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Predictor state: our own copy of every wait queue and its length.
   logic [4:0] lock_queue [NRES][NPROC];
   int         lock_len   [NRES];

   // Results still owed by the block, oldest first.
   rsp_type    owed_results [$];
   int         error_count = 0;
   int         checked_count = 0;

   resource_wait_queue_manager DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // Safety net: the slowest correct run is far below this.
   initial begin
      #200ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Return the position of a process in a queue, or -1 when absent.
   function automatic int locate(int res, logic [4:0] pid);
      for (int k = 0; k < lock_len[res]; k++) begin
         if (lock_queue[res][k] == pid) return k;
      end
      return -1;
   endfunction

   // Close the gap left by removing one queue entry.
   function automatic void unlink(int res, int pos);
      for (int k = pos; k + 1 < lock_len[res]; k++) begin
         lock_queue[res][k] = lock_queue[res][k + 1];
      end
      lock_len[res]--;
   endfunction

   // Apply one request to the lock table and return the expected result.
   function automatic rsp_type apply_lock_op(req_type rq);
      rsp_type    res_out;
      int         r;
      int         pos;
      int         removed;
      logic       addressed;
      logic [2:0] st;
      r = rq.resource_id;
      st = ST_OK;
      removed = 0;
      addressed = 1'b1;
      case (op_type'(rq.op))
         OP_REQUEST: begin
            if (lock_len[r] == 0) begin
               lock_queue[r][0] = rq.process_id;
               lock_len[r] = 1;
            end else if (locate(r, rq.process_id) >= 0 || lock_len[r] >= NPROC) begin
               st = ST_QUEUED;
            end else begin
               lock_queue[r][lock_len[r]] = rq.process_id;
               lock_len[r]++;
            end
         end
         OP_RELEASE: begin
            if (lock_len[r] == 0) st = ST_FREE;
            else if (lock_queue[r][0] == rq.process_id) unlink(r, 0);
            else st = ST_NOT_OWNER;
         end
         OP_KILL: begin
            addressed = 1'b0;
            for (int i = 0; i < NRES; i++) begin
               pos = locate(i, rq.process_id);
               if (pos >= 0) begin
                  unlink(i, pos);
                  removed++;
               end
            end
            if (removed == 0) st = ST_NOT_FOUND;
         end
         default: begin
            addressed = 1'b0;
            for (int i = 0; i < NRES; i++) lock_len[i] = 0;
         end
      endcase
      res_out = '0;
      res_out.status = st;
      if (addressed && lock_len[r] != 0) begin
         res_out.owner_valid  = 1'b1;
         res_out.owner_id     = lock_queue[r][0];
         res_out.queue_length = 6'(lock_len[r]);
      end
      res_out.removed_count = 6'(removed);
      return res_out;
   endfunction

   // Compare every strobed result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            error_count++;
         end else begin
            rsp_type want;
            want = owed_results.pop_front();
            checked_count++;
            if (rsp_data.status !== want.status)
               $display("%0t: status exp %0d got %0d", $time, want.status, rsp_data.status);
            if (rsp_data.owner_valid !== want.owner_valid)
               $display("%0t: owner_valid exp %0d got %0d", $time, want.owner_valid,
                        rsp_data.owner_valid);
            if (rsp_data.owner_id !== want.owner_id)
               $display("%0t: owner_id exp %0d got %0d", $time, want.owner_id,
                        rsp_data.owner_id);
            if (rsp_data.queue_length !== want.queue_length)
               $display("%0t: queue_length exp %0d got %0d", $time, want.queue_length,
                        rsp_data.queue_length);
            if (rsp_data.removed_count !== want.removed_count)
               $display("%0t: removed_count exp %0d got %0d", $time, want.removed_count,
                        rsp_data.removed_count);
            if (rsp_data !== want) error_count++;
         end
      end
   end

   // Burst and gap control for the sender.
   int burst_left = 0;

   // Hand one request to the block: wait out busy, hold start for the taking edge.
   task automatic issue(req_type rq, logic has_typed, rsp_type typed);
      rsp_type predicted;
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      // Request taken at this edge; predict it now, before its result can strobe.
      predicted = apply_lock_op(rq);
      if (has_typed && predicted !== typed) begin
         $display("%0t: table row disagrees with predictor exp %p got %p",
                  $time, typed, predicted);
         error_count++;
      end
      owed_results.push_back(predicted);
      start <= 1'b0;
      // The block is busy with this request for the next cycle anyway.
      @(posedge clock);
   endtask

   function automatic req_type mk(op_type op, int res, int pid);
      req_type rq;
      rq.op = op;
      rq.resource_id = 5'(res);
      rq.process_id = 5'(pid);
      return rq;
   endfunction

   function automatic rsp_type rs(status_type st, logic ov, int own, int len, int rem);
      rsp_type x;
      x.status = st;
      x.owner_valid = ov;
      x.owner_id = 5'(own);
      x.queue_length = 6'(len);
      x.removed_count = 6'(rem);
      return x;
   endfunction

   typedef struct {
      req_type    rq;
      logic       typed;
      rsp_type    want;
   } row_type;

   // Directed table: extremes, each op, and each special case.
   row_type dir_rows [$];

   // Keep a small working set so queues fill, clash and get released.
   task automatic random_phase(int count);
      req_type rq;
      int      pick;
      int      res_max;
      int      pid_max;
      for (int n = 0; n < count; n++) begin
         res_max = ($urandom_range(0, 3) == 0) ? 31 : 3;
         pid_max = ($urandom_range(0, 3) == 0) ? 31 : 7;
         rq.resource_id = 5'($urandom_range(0, res_max));
         rq.process_id  = 5'($urandom_range(0, pid_max));
         pick = $urandom_range(0, 99);
         if (pick < 50) rq.op = OP_REQUEST;
         else if (pick < 80) begin
            rq.op = OP_RELEASE;
            // Mostly the real owner, so ownership actually moves on.
            if (lock_len[rq.resource_id] != 0 && $urandom_range(0, 2) != 0)
               rq.process_id = lock_queue[rq.resource_id][0];
         end else if (pick < 98) rq.op = OP_KILL;
         else rq.op = OP_CLEAR;
         issue(rq, 1'b0, '0);
      end
   endtask

   initial begin
      for (int i = 0; i < NRES; i++) lock_len[i] = 0;

      dir_rows.push_back('{mk(OP_RELEASE, 0, 0), 1'b1, rs(ST_FREE, 0, 0, 0, 0)});
      dir_rows.push_back('{mk(OP_KILL, 0, 31), 1'b1, rs(ST_NOT_FOUND, 0, 0, 0, 0)});
      dir_rows.push_back('{mk(OP_REQUEST, 31, 31), 1'b1, rs(ST_OK, 1, 31, 1, 0)});
      dir_rows.push_back('{mk(OP_REQUEST, 31, 0), 1'b1, rs(ST_OK, 1, 31, 2, 0)});
      dir_rows.push_back('{mk(OP_REQUEST, 31, 0), 1'b1, rs(ST_QUEUED, 1, 31, 2, 0)});
      dir_rows.push_back('{mk(OP_RELEASE, 31, 0), 1'b1, rs(ST_NOT_OWNER, 1, 31, 2, 0)});
      dir_rows.push_back('{mk(OP_REQUEST, 0, 0), 1'b1, rs(ST_OK, 1, 0, 1, 0)});
      dir_rows.push_back('{mk(OP_REQUEST, 0, 31), 1'b1, rs(ST_OK, 1, 0, 2, 0)});
      dir_rows.push_back('{mk(OP_KILL, 17, 31), 1'b1, rs(ST_OK, 0, 0, 0, 2)});
      dir_rows.push_back('{mk(OP_RELEASE, 31, 0), 1'b1, rs(ST_OK, 0, 0, 0, 0)});
      dir_rows.push_back('{mk(OP_REQUEST, 21, 10), 1'b0, '0});
      dir_rows.push_back('{mk(OP_REQUEST, 10, 21), 1'b0, '0});
      dir_rows.push_back('{mk(OP_CLEAR, 31, 31), 1'b1, rs(ST_OK, 0, 0, 0, 0)});
      dir_rows.push_back('{mk(OP_RELEASE, 0, 0), 1'b1, rs(ST_FREE, 0, 0, 0, 0)});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) issue(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

      // Fill one queue to its limit, then push a 33rd request for the full-queue case.
      for (int p = 0; p < NPROC; p++) issue(mk(OP_REQUEST, 5, p), 1'b0, '0);
      issue(mk(OP_REQUEST, 5, 0), 1'b0, '0);
      issue(mk(OP_REQUEST, 6, 7), 1'b0, '0);
      issue(mk(OP_KILL, 0, 7), 1'b0, '0);
      issue(mk(OP_CLEAR, 0, 0), 1'b0, '0);

      random_phase(RANDOM_REQUESTS);

      // Drain: wait for every owed result, then a short settle.
      while (owed_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      if (error_count == 0 && owed_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
